/* hdl/multi_channel_quadrature_counter_top_defines.svh */
// ----------------------------------------------------------------------------
// multi channel quadrature counter assertion macros
// shared concurrent check forms for the counter rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_QUADRATURE_COUNTER_TOP_DEFINES_SVH
`define MULTI_CHANNEL_QUADRATURE_COUNTER_TOP_DEFINES_SVH

// same-cycle implication
`define MCQC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCQC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mcqc_pkg.sv */
// ----------------------------------------------------------------------------
// mcqc_pkg
// types and constants of the multi channel quadrature counter
// ----------------------------------------------------------------------------
`default_nettype none

package mcqc_pkg;

    localparam int CHANNELS_DEFAULT = 7;
    localparam int CHAN_SLOTS       = 8;
    localparam int CHAN_W           = 3;
    localparam int CMD_W            = 3;
    localparam int COUNT_W          = 32;
    localparam int S_TDATA_W        = 40;
    localparam int M_TDATA_W        = 40;

    localparam logic [COUNT_W-1:0] COUNT_MOST_NEG = 32'h8000_0000;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE    = 3'd0,
        CMD_PRESET  = 3'd1,
        CMD_REP_CHG = 3'd2,
        CMD_REP_ALL = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_EMIT,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic              wr;
        logic              load;
        logic              up;
        logic              set_flag;
        logic              clr_flag;
        logic [CHAN_W-1:0] ptr;
    } store_ctrl_t;

endpackage

`default_nettype wire

/* hdl/multi_channel_quadrature_counter_top.sv */
// ----------------------------------------------------------------------------
// multi_channel_quadrature_counter_top
// x2 quadrature position counter for up to eight encoder channels
// ----------------------------------------------------------------------------
// usage
//   s_ channel takes one command per transaction: s_tuser is the command,
//   s_tdata carries channel, phase levels and preset value. m_ channel gives
//   position reports and read replies; m_tlast marks the final result of a
//   command. one command is worked at a time; s_tready is high only while
//   the sequencer is idle.
// sequencing
//   edge event: accept, then one pass through the shared add/load unit in
//   the edge state. preset and read: accept, then the result is registered
//   from the emit state once the output register is free. report changed /
//   report all: the scan pointer steps through every channel, one per cycle
//   unless a selected channel waits for a free output register; one count adder serves all channels.
// reset
//   aresetn low clears all counts and changed flags at once; no sweep.
// back pressure
//   a result waits in the output register; the sequencer holds its channel
//   while that register is full and m_tready is low, so nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_quadrature_counter_top_defines.svh"

module multi_channel_quadrature_counter_top #(
    parameter int CHANNELS = mcqc_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // channel[2:0], phase_a[3], phase_b[4], preset_value[36:5], zero pad
    input  wire logic [mcqc_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[2:0]
    input  wire logic [mcqc_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_channel[2:0], count[34:3], zero pad
    output logic [mcqc_pkg::M_TDATA_W-1:0]        m_tdata,
    // result_kind[0]
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    localparam logic [mcqc_pkg::CHAN_W:0] CHAN_LIM = (mcqc_pkg::CHAN_W+1)'(CHANNELS);

    mcqc_pkg::state_t state_reg, state_next;

    logic [mcqc_pkg::CMD_W-1:0]          cmd_reg, cmd_next;
    logic [mcqc_pkg::CHAN_W-1:0]         ptr_reg, ptr_next;
    logic                                eq_reg, eq_next;
    logic                                valid_reg, valid_next;
    logic signed [mcqc_pkg::COUNT_W-1:0] preset_reg, preset_next;

    logic                                m_tvalid_reg;
    logic                                m_tuser_reg;
    logic                                m_tlast_reg;
    logic [mcqc_pkg::M_TDATA_W-1:0]      m_tdata_reg;

    logic                                out_load;
    logic                                out_kind;
    logic                                out_last;
    logic signed [mcqc_pkg::COUNT_W-1:0] out_count;

    mcqc_pkg::store_ctrl_t               store_ctrl;
    logic signed [mcqc_pkg::COUNT_W-1:0] rd_count;
    logic [mcqc_pkg::CHAN_SLOTS-1:0]     chg_flags;

    logic [mcqc_pkg::CHAN_W-1:0]         in_chan;
    logic                                in_valid_ch;
    logic                                accept;
    logic                                slot_free;
    logic                                scan_all;
    logic                                sel;
    logic                                at_end;
    logic                                more;
    logic [mcqc_pkg::CHAN_SLOTS-1:0]     rest_mask;

    assign in_chan     = s_tdata[2:0];
    assign in_valid_ch = {1'b0, in_chan} < CHAN_LIM;
    assign accept      = s_tvalid && s_tready;
    assign slot_free   = !m_tvalid_reg || m_tready;
    assign scan_all    = cmd_reg == mcqc_pkg::CMD_REP_ALL;
    assign sel         = scan_all || chg_flags[ptr_reg];
    assign at_end      = {1'b0, ptr_reg} == CHAN_LIM - (mcqc_pkg::CHAN_W+1)'(1);

    // selected channels still ahead of the scan pointer
    always_comb begin
        for (int i = 0; i < mcqc_pkg::CHAN_SLOTS; i++) begin
            rest_mask[i] = (mcqc_pkg::CHAN_W'(i) > ptr_reg) && (i < CHANNELS)
                           && (scan_all || chg_flags[i]);
        end
    end
    assign more = |rest_mask;

    mcqc_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (store_ctrl),
        .preset   (preset_reg),
        .rd_count (rd_count),
        .flags    (chg_flags)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcqc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        mcqc_pkg::CMD_EDGE: begin
                            state_next = in_valid_ch ? mcqc_pkg::ST_EDGE : mcqc_pkg::ST_IDLE;
                        end
                        mcqc_pkg::CMD_PRESET: begin
                            state_next = in_valid_ch ? mcqc_pkg::ST_EMIT : mcqc_pkg::ST_IDLE;
                        end
                        mcqc_pkg::CMD_READ: begin
                            state_next = mcqc_pkg::ST_EMIT;
                        end
                        mcqc_pkg::CMD_REP_CHG, mcqc_pkg::CMD_REP_ALL: begin
                            state_next = mcqc_pkg::ST_SCAN;
                        end
                        default: begin
                            state_next = mcqc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mcqc_pkg::ST_EDGE: begin
                state_next = mcqc_pkg::ST_IDLE;
            end
            mcqc_pkg::ST_EMIT: begin
                if (slot_free) begin
                    state_next = mcqc_pkg::ST_IDLE;
                end
            end
            mcqc_pkg::ST_SCAN: begin
                if ((!sel || slot_free) && at_end) begin
                    state_next = mcqc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mcqc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_tready    = state_reg == mcqc_pkg::ST_IDLE;
        cmd_next    = cmd_reg;
        ptr_next    = ptr_reg;
        eq_next     = eq_reg;
        valid_next  = valid_reg;
        preset_next = preset_reg;
        out_load    = 1'b0;
        out_kind    = mcqc_pkg::KIND_REPORT;
        out_last    = 1'b0;
        out_count   = rd_count;
        store_ctrl          = '0;
        store_ctrl.ptr      = ptr_reg;
        store_ctrl.up       = eq_reg;
        case (state_reg)
            mcqc_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_next    = s_tuser;
                    eq_next     = s_tdata[3] == s_tdata[4];
                    valid_next  = in_valid_ch;
                    preset_next = s_tdata[36:5];
                    if (s_tuser == mcqc_pkg::CMD_REP_CHG || s_tuser == mcqc_pkg::CMD_REP_ALL) begin
                        ptr_next = '0;
                    end else begin
                        ptr_next = in_chan;
                    end
                end
            end
            mcqc_pkg::ST_EDGE: begin
                store_ctrl.wr       = 1'b1;
                store_ctrl.set_flag = 1'b1;
            end
            mcqc_pkg::ST_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    if (cmd_reg == mcqc_pkg::CMD_READ) begin
                        out_kind  = mcqc_pkg::KIND_READ;
                        out_count = valid_reg ? rd_count : mcqc_pkg::COUNT_MOST_NEG;
                    end else begin
                        out_count           = preset_reg;
                        store_ctrl.wr       = 1'b1;
                        store_ctrl.load     = 1'b1;
                        store_ctrl.clr_flag = 1'b1;
                    end
                end
            end
            mcqc_pkg::ST_SCAN: begin
                if (sel && slot_free) begin
                    out_load            = 1'b1;
                    out_last            = !more;
                    store_ctrl.clr_flag = 1'b1;
                end
                if ((!sel || slot_free) && !at_end) begin
                    ptr_next = ptr_reg + mcqc_pkg::CHAN_W'(1);
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mcqc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        ptr_reg    <= ptr_next;
        eq_reg     <= eq_next;
        valid_reg  <= valid_next;
        preset_reg <= preset_next;
        if (out_load) begin
            m_tuser_reg <= out_kind;
            m_tlast_reg <= out_last;
            m_tdata_reg <= {5'b0, out_count, ptr_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    `MCQC_ASSERT_NEXT(a_edge_goes_update, aclk, aresetn, accept && s_tuser == mcqc_pkg::CMD_EDGE && in_valid_ch, state_reg == mcqc_pkg::ST_EDGE, "edge transaction did not reach update")
    `MCQC_ASSERT_SAME(a_scan_in_range, aclk, aresetn, state_reg == mcqc_pkg::ST_SCAN, ({1'b0, ptr_reg} < CHAN_LIM), "scan pointer beyond channel count")
    `MCQC_ASSERT_NEXT(a_preset_flag_clear, aclk, aresetn, state_reg == mcqc_pkg::ST_EMIT && cmd_reg == mcqc_pkg::CMD_PRESET && slot_free, !chg_flags[$past(ptr_reg)], "preset left changed flag set")

endmodule

`default_nettype wire

/* hdl/mcqc_store.sv */
// ----------------------------------------------------------------------------
// mcqc_store
// per channel position counts and changed flags with the shared update adder
// ----------------------------------------------------------------------------
`default_nettype none

module mcqc_store (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire mcqc_pkg::store_ctrl_t                   ctrl,
    input  wire logic signed [mcqc_pkg::COUNT_W-1:0]     preset,
    output logic signed [mcqc_pkg::COUNT_W-1:0]          rd_count,
    output logic [mcqc_pkg::CHAN_SLOTS-1:0]              flags
);

    logic signed [mcqc_pkg::COUNT_W-1:0] counts_reg [mcqc_pkg::CHAN_SLOTS];
    logic [mcqc_pkg::CHAN_SLOTS-1:0]     flags_reg;
    logic signed [mcqc_pkg::COUNT_W-1:0] upd_next;
    logic signed [mcqc_pkg::COUNT_W-1:0] delta;

    assign rd_count = counts_reg[ctrl.ptr];
    assign flags    = flags_reg;

    // shared unit: load or step by one
    assign delta    = ctrl.up ? mcqc_pkg::COUNT_W'(1) : {mcqc_pkg::COUNT_W{1'b1}};
    assign upd_next = ctrl.load ? preset : rd_count + delta;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mcqc_pkg::CHAN_SLOTS; i++) begin
                counts_reg[i] <= '0;
            end
            flags_reg <= '0;
        end else begin
            if (ctrl.wr) begin
                counts_reg[ctrl.ptr] <= upd_next;
            end
            if (ctrl.set_flag) begin
                flags_reg[ctrl.ptr] <= 1'b1;
            end else if (ctrl.clr_flag) begin
                flags_reg[ctrl.ptr] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* dv/tb_multi_channel_quadrature_counter_top.sv */
// ----------------------------------------------------------------------------
// tb_multi_channel_quadrature_counter_top
// self-checking bench for the multi channel quadrature position counter:
// a directed command table, then random edge, preset, read, report and
// reserved-command traffic, with random stalls on both stream channels in
// the first two thirds. every result transaction is compared field by field
// against its typed table row or a cycle-free model of the channel counts and changed flags.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_channel_quadrature_counter_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mcqc_pkg::*;

    localparam int NUM_CH       = CHANNELS_DEFAULT;
    localparam int PLAN_ROWS    = 25;
    localparam int RANDOM_ITEMS = 345;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic                 kind;
        logic [CHAN_W-1:0]    chan;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } count_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]     op;
        logic [CHAN_W-1:0]    ch;
        logic                 pa;
        logic                 pb;
        logic [COUNT_W-1:0]   preset;
        logic                 typed;
        logic                 typed_hit;
        logic                 xkind;
        logic [CHAN_W-1:0]    xch;
        logic [COUNT_W-1:0]   xcount;
    } counter_cmd_t;

    // typed rows carry their single result (or none); the rest use the predictor
    localparam counter_cmd_t PLAN [PLAN_ROWS] = '{
        '{CMD_READ,    3'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b1, KIND_READ,   3'd0, 32'h0},
        '{CMD_READ,    3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_READ,   3'd7,
          COUNT_MOST_NEG},
        '{CMD_REP_CHG, 3'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_REP_ALL, 3'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_PRESET,  3'd3, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b1, KIND_REPORT, 3'd3,
          32'h7FFF_FFFF},
        '{CMD_EDGE,    3'd3, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_READ,    3'd3, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b1, KIND_READ,   3'd3,
          COUNT_MOST_NEG},
        '{CMD_PRESET,  3'd6, 1'b0, 1'b0, COUNT_MOST_NEG, 1'b1, 1'b1, KIND_REPORT, 3'd6,
          COUNT_MOST_NEG},
        '{CMD_EDGE,    3'd6, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_READ,    3'd6, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b1, KIND_READ,   3'd6,
          32'h7FFF_FFFF},
        '{CMD_EDGE,    3'd0, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_EDGE,    3'd0, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_EDGE,    3'd1, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_EDGE,    3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_PRESET,  3'd7, 1'b0, 1'b0, 32'h5A5A_5A5A, 1'b1, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_REP_CHG, 3'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_REP_CHG, 3'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_RSVD5,   3'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_RSVD6,   3'd5, 1'b0, 1'b1, 32'h1234_5678, 1'b1, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_RSVD7,   3'd7, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_PRESET,  3'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_REPORT, 3'd0,
          32'hFFFF_FFFF},
        '{CMD_EDGE,    3'd5, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_REP_ALL, 3'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_READ,    3'd2, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, KIND_REPORT, 3'd0, 32'h0},
        '{CMD_PRESET,  3'd2, 1'b1, 1'b0, 32'h0000_0000, 1'b1, 1'b1, KIND_REPORT, 3'd2, 32'h0}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [CMD_W-1:0]       s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    int send_idle_pct = 15;
    int recv_idle_pct = 76;
    int mismatches    = 0;

    logic [COUNT_W-1:0] enc_count [NUM_CH];
    logic               enc_moved [NUM_CH];
    count_result_t      step_results [$];
    count_result_t      awaited_counts [$];

    multi_channel_quadrature_counter_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // model of counts and flags; leaves the results of one command in step_results
    function automatic void advance_encoder(input logic [CMD_W-1:0] op,
                                            input logic [CHAN_W-1:0] ch,
                                            input logic pa, input logic pb,
                                            input logic [COUNT_W-1:0] preset);
        logic          ok;
        int            i;
        count_result_t r;
        ok = (ch < NUM_CH);
        step_results.delete();
        case (op)
            CMD_EDGE: begin
                if (ok) begin
                    enc_count[ch] = (pa == pb) ? enc_count[ch] + 1'b1 : enc_count[ch] - 1'b1;
                    enc_moved[ch] = 1'b1;
                end
            end
            CMD_PRESET: begin
                if (ok) begin
                    enc_count[ch] = preset;
                    enc_moved[ch] = 1'b0;
                    step_results.push_back('{KIND_REPORT, ch, preset, 1'b0});
                end
            end
            CMD_REP_CHG, CMD_REP_ALL: begin
                for (i = 0; i < NUM_CH; i++) begin
                    if (op == CMD_REP_ALL || enc_moved[i]) begin
                        enc_moved[i] = 1'b0;
                        step_results.push_back('{KIND_REPORT, CHAN_W'(i), enc_count[i], 1'b0});
                    end
                end
            end
            CMD_READ: begin
                step_results.push_back('{KIND_READ, ch, ok ? enc_count[ch] : COUNT_MOST_NEG,
                                         1'b0});
            end
            default: begin
            end
        endcase
        if (step_results.size() > 0) begin
            r = step_results[step_results.size() - 1];
            r.last = 1'b1;
            step_results[step_results.size() - 1] = r;
        end
    endfunction

    task automatic send_command(input counter_cmd_t c);
        count_result_t r;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {3'b000, c.preset, c.pb, c.pa, c.ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_encoder(c.op, c.ch, c.pa, c.pb, c.preset);
        if (c.typed) begin
            if (c.typed_hit) begin
                r = '{c.xkind, c.xch, c.xcount, 1'b1};
                awaited_counts.push_back(r);
            end
        end else begin
            foreach (step_results[i]) awaited_counts.push_back(step_results[i]);
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        count_result_t got;
        count_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[2:0], m_tdata[34:3], m_tlast};
            if (awaited_counts.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction kind %0d ch %0d count %0d",
                                          got.kind, got.chan, $signed(got.count)));
            end else begin
                want = awaited_counts.pop_front();
                if (got.kind != want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                if (got.chan != want.chan)
                    report_mismatch($sformatf("channel %0d, expected %0d", got.chan, want.chan));
                if (got.count != want.count)
                    report_mismatch($sformatf("ch %0d count %0d, expected %0d", want.chan,
                                              $signed(got.count), $signed(want.count)));
                if (got.last != want.last)
                    report_mismatch($sformatf("ch %0d last %0d, expected %0d", want.chan,
                                              got.last, want.last));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        counter_cmd_t c;
        int           done;
        int           pick;
        for (int i = 0; i < NUM_CH; i++) begin
            enc_count[i] = '0;
            enc_moved[i] = 1'b0;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) send_command(PLAN[i]);

        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done < RANDOM_ITEMS / 3) begin
                send_idle_pct = 15;
                recv_idle_pct = 76;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 76;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            c = '0;
            c.pa = 1'($urandom_range(1));
            c.pb = 1'($urandom_range(1));
            c.ch = ($urandom_range(19) == 0) ? CHAN_W'(NUM_CH) : CHAN_W'($urandom_range(NUM_CH - 1));
            case ($urandom_range(3))
                0:       c.preset = COUNT_MOST_NEG;
                1:       c.preset = 32'h7FFF_FFFF;
                default: c.preset = $urandom();
            endcase
            pick = $urandom_range(99);
            if (pick < 55)
                c.op = CMD_EDGE;
            else if (pick < 65)
                c.op = CMD_PRESET;
            else if (pick < 77) begin
                c.op = CMD_READ;
                c.ch = CHAN_W'($urandom_range(7));
            end else if (pick < 87)
                c.op = CMD_REP_CHG;
            else if (pick < 91)
                c.op = CMD_REP_ALL;
            else begin
                c.op = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
                c.ch = CHAN_W'($urandom_range(7));
            end
            send_command(c);
            done++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_counts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
